// File: design/rtmg_pkg.sv
// rtmg_pkg: shared types, constants and the gamma threshold table for the
// reinhard tone map and gamma block; no dependencies
`timescale 1ns / 1ps

package rtmg_pkg;

    localparam int FRACTION_BITS    = 16;
    localparam int GAMMA_INDEX_BITS = 12;

    localparam int RAD_BITS    = 32;
    localparam int BYTE_BITS   = 8;
    localparam int REM_BITS    = RAD_BITS + 2;
    localparam int DIV_STAGES  = GAMMA_INDEX_BITS;
    localparam int GAMMA_STEPS = BYTE_BITS;
    localparam int LEVELS      = 1 << BYTE_BITS;
    localparam int LATENCY     = DIV_STAGES + 1 + GAMMA_STEPS + 1;
    localparam int WIDE_BITS   = 5 * GAMMA_INDEX_BITS + 96;

    localparam logic [REM_BITS-1:0] ONE_FIXED = REM_BITS'(1) << FRACTION_BITS;

    typedef struct packed {
        logic [RAD_BITS-1:0] red_radiance;
        logic [RAD_BITS-1:0] green_radiance;
        logic [RAD_BITS-1:0] blue_radiance;
    } pixel_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] red_byte;
        logic [BYTE_BITS-1:0] green_byte;
        logic [BYTE_BITS-1:0] blue_byte;
    } result_t;

    typedef logic [GAMMA_INDEX_BITS:0] thresh_t;
    typedef thresh_t thresh_table_t [LEVELS];

    function automatic logic [WIDE_BITS-1:0] wide_pow(input int base, input int exp);
        logic [WIDE_BITS-1:0] acc;
        acc = WIDE_BITS'(1);
        for (int i = 0; i < exp; i++)
        begin
            acc = acc * WIDE_BITS'(base);
        end
        return acc;
    endfunction

    // smallest index whose gamma byte reaches each level
    function automatic thresh_table_t build_thresholds();
        thresh_table_t        t;
        logic [WIDE_BITS-1:0] scale;
        logic [WIDE_BITS-1:0] lhs;
        logic [WIDE_BITS-1:0] rhs;
        int                   lo;
        int                   hi;
        int                   mid;
        scale = wide_pow(255, 11);
        for (int v = 0; v < LEVELS; v++)
        begin
            lhs = wide_pow(v, 11) << (5 * GAMMA_INDEX_BITS);
            lo  = 0;
            hi  = 1 << GAMMA_INDEX_BITS;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                rhs = wide_pow(mid, 5) * scale;
                if (rhs >= lhs)
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 1;
                end
            end
            t[v] = thresh_t'(lo);
        end
        return t;
    endfunction

    localparam thresh_table_t GAMMA_THRESH = build_thresholds();

endpackage

// File: design/rtmg_div.sv
// rtmg_div: pipelined restoring divider giving the quantised reinhard ratio
// of one channel, one quotient bit per stage; depends on rtmg_pkg
`timescale 1ns / 1ps

module rtmg_div (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [rtmg_pkg::RAD_BITS-1:0]         radiance,
    output logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] idx
);

    logic [rtmg_pkg::REM_BITS-1:0]         rem_reg [rtmg_pkg::DIV_STAGES];
    logic [rtmg_pkg::REM_BITS-1:0]         den_reg [rtmg_pkg::DIV_STAGES];
    logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] q_reg   [rtmg_pkg::DIV_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rtmg_pkg::REM_BITS'(radiance);
            den_reg[0] <= rtmg_pkg::REM_BITS'(radiance) + rtmg_pkg::ONE_FIXED;
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 1; s <= rtmg_pkg::DIV_STAGES; s++)
    begin : g_stage
        logic [rtmg_pkg::REM_BITS-1:0] shifted;
        logic                          ge;

        assign shifted = {rem_reg[s-1][rtmg_pkg::REM_BITS-2:0], 1'b0};
        assign ge      = shifted >= den_reg[s-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s] <= {q_reg[s-1][rtmg_pkg::GAMMA_INDEX_BITS-2:0], ge};
            end
        end

        if (s < rtmg_pkg::DIV_STAGES)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? shifted - den_reg[s-1] : shifted;
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    assign idx = q_reg[rtmg_pkg::DIV_STAGES];

endmodule

// File: design/rtmg_gamma.sv
// rtmg_gamma: pipelined binary search of the gamma threshold table, one
// output bit per stage; depends on rtmg_pkg
`timescale 1ns / 1ps

module rtmg_gamma (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] idx,
    output logic [rtmg_pkg::BYTE_BITS-1:0]        value
);

    logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] idx_reg [rtmg_pkg::GAMMA_STEPS-1];
    logic [rtmg_pkg::BYTE_BITS-1:0]        v_reg   [rtmg_pkg::GAMMA_STEPS];

    for (genvar k = 0; k < rtmg_pkg::GAMMA_STEPS; k++)
    begin : g_step
        logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] idx_in;
        logic [rtmg_pkg::BYTE_BITS-1:0]        v_in;
        logic [rtmg_pkg::BYTE_BITS-1:0]        cand;
        logic                                  take;

        if (k == 0)
        begin : g_first
            assign idx_in = idx;
            assign v_in   = '0;
        end
        else
        begin : g_next
            assign idx_in = idx_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        assign cand = v_in | (rtmg_pkg::BYTE_BITS'(1) << (rtmg_pkg::BYTE_BITS - 1 - k));
        assign take = {1'b0, idx_in} >= rtmg_pkg::GAMMA_THRESH[cand];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= take ? cand : v_in;
            end
        end

        if (k < rtmg_pkg::GAMMA_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    idx_reg[k] <= idx_in;
                end
            end
        end
    end

    assign value = v_reg[rtmg_pkg::GAMMA_STEPS-1];

endmodule

// File: design/reinhard_tone_map_gamma_top.sv
// Reinhard tone mapping with gamma 1/2.2: three channel lanes of divider and
// gamma search feeding an output register. One pixel is accepted every clock
// cycle while the output is not stalled; each result passes through the
// one-bit-per-stage divider and the eight-step gamma table search in its lane
// and then the output register. A stalled output freezes the whole pipeline
// and the input stall follows it in the same cycle.
// Depends on rtmg_pkg, rtmg_div and rtmg_gamma.
`timescale 1ns / 1ps

module reinhard_tone_map_gamma_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  rtmg_pkg::pixel_t  pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output rtmg_pkg::result_t result
);

    logic [rtmg_pkg::LATENCY-1:0] valid_reg;
    logic [rtmg_pkg::LATENCY-1:0] valid_next;
    logic                         en;

    logic [rtmg_pkg::RAD_BITS-1:0]         radiance [3];
    logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] idx      [3];
    logic [rtmg_pkg::BYTE_BITS-1:0]        value    [3];

    rtmg_pkg::result_t result_reg;

    assign en          = !valid_reg[rtmg_pkg::LATENCY-1] || !result_stall;
    assign pixel_stall = !en;

    assign radiance[0] = pixel.red_radiance;
    assign radiance[1] = pixel.green_radiance;
    assign radiance[2] = pixel.blue_radiance;

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        rtmg_div u_div (
            .clk      (clk),
            .en       (en),
            .radiance (radiance[c]),
            .idx      (idx[c])
        );

        rtmg_gamma u_gamma (
            .clk   (clk),
            .en    (en),
            .idx   (idx[c]),
            .value (value[c])
        );
    end

    assign valid_next = {valid_reg[rtmg_pkg::LATENCY-2:0], pixel_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // merge the three lanes into one result item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.red_byte   <= value[0];
            result_reg.green_byte <= value[1];
            result_reg.blue_byte  <= value[2];
        end
    end

    assign result_valid = valid_reg[rtmg_pkg::LATENCY-1];
    assign result       = result_reg;

endmodule

// File: design/rtmg_checker.sv
// rtmg_checker: port-level assertions for the tone map top level, bound to it
// below; depends on rtmg_pkg
`timescale 1ns / 1ps

module rtmg_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pixel_valid,
    input logic              pixel_stall,
    input logic              result_valid,
    input logic              result_stall,
    input rtmg_pkg::result_t result
);

    // input only held back by a waiting item at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("input stalled with no blocked item");

    // ratio stays below one so no byte reaches full scale
    a_no_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.red_byte != 8'hFF && result.green_byte != 8'hFF
                         && result.blue_byte != 8'hFF)
        else $error("byte at full scale");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("item dropped while stalled");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled item changed");

endmodule

bind reinhard_tone_map_gamma_top rtmg_checker u_checker (.*);

// File: test/reinhard_tone_map_gamma_top_test.sv
// reinhard_tone_map_gamma_top_test: self-checking bench for the reinhard tone map
// and gamma block, with directed extremes, random pixels, idling and backpressure
// depends on rtmg_pkg and reinhard_tone_map_gamma_top
`timescale 1ns / 1ps

module reinhard_tone_map_gamma_top_test;

    typedef logic [159:0] big_t;

    logic              clk;
    logic              rst_n;
    logic              pixel_valid;
    logic              pixel_stall;
    rtmg_pkg::pixel_t  pixel_in;
    logic              result_valid;
    logic              result_stall;
    rtmg_pkg::result_t result_out;

    rtmg_pkg::result_t expected_bytes[$];
    int                failures;
    int                pixels_sent;
    int                results_checked;
    int                saturated_bytes;
    int                zero_bytes;
    int                input_stall_cycles;
    int                sender_idle_max;
    int                receiver_idle_max;
    int                hold_request;

    reinhard_tone_map_gamma_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic big_t big_power(input int unsigned base, input int n);
        big_t acc;
        acc = big_t'(1);
        for (int i = 0; i < n; i++)
        begin
            acc = acc * big_t'(base);
        end
        return acc;
    endfunction

    function automatic logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] reinhard_index(
        input logic [31:0] c);
        logic [63:0] num;
        logic [63:0] den;
        num = {32'd0, c} << rtmg_pkg::GAMMA_INDEX_BITS;
        den = {32'd0, c} + (64'd1 << rtmg_pkg::FRACTION_BITS);
        return rtmg_pkg::GAMMA_INDEX_BITS'(num / den);
    endfunction

    // largest level whose 2.2 power stays at or below the index ratio
    function automatic logic [7:0] gamma_level(
        input logic [rtmg_pkg::GAMMA_INDEX_BITS-1:0] idx);
        big_t       bound;
        big_t       trial;
        logic [7:0] level;
        logic [7:0] cand;
        bound = big_power(int'(idx), 5) * big_power(255, 11);
        level = 8'd0;
        for (int b = 7; b >= 0; b--)
        begin
            cand  = level | (8'd1 << b);
            trial = big_power(int'(cand), 11) << (5 * rtmg_pkg::GAMMA_INDEX_BITS);
            if (trial <= bound)
            begin
                level = cand;
            end
        end
        return level;
    endfunction

    function automatic rtmg_pkg::result_t tone_map_pixel(input rtmg_pkg::pixel_t p);
        rtmg_pkg::result_t r;
        r.red_byte   = gamma_level(reinhard_index(p.red_radiance));
        r.green_byte = gamma_level(reinhard_index(p.green_radiance));
        r.blue_byte  = gamma_level(reinhard_index(p.blue_radiance));
        return r;
    endfunction

    function automatic int idle_draw(input int max_wait);
        if (max_wait == 0 || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, max_wait);
    endfunction

    // spread over magnitudes so the whole gamma curve is reached
    function automatic logic [31:0] random_radiance();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom >> $urandom_range(0, 31);
            4, 5, 6:    return $urandom;
            7:          return 32'h0000_ff00 + $urandom_range(0, 512);
            8:          return $urandom_range(0, 64);
            default:    return 32'hffff_ffff - $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_pixel(input rtmg_pkg::pixel_t p);
        int gap;
        gap = idle_draw(sender_idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_in    <= p;
        do
        begin
            @(posedge clk);
        end
        while (pixel_stall);
        expected_bytes.push_back(tone_map_pixel(p));
        pixels_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        pixel_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        release_input();
        while (expected_bytes.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_random(input int count, input int send_max, input int recv_max);
        rtmg_pkg::pixel_t p;
        sender_idle_max   = send_max;
        receiver_idle_max = recv_max;
        for (int i = 0; i < count; i++)
        begin
            p.red_radiance   = random_radiance();
            p.green_radiance = random_radiance();
            p.blue_radiance  = random_radiance();
            send_pixel(p);
        end
        wait_for_results();
    endtask

    task automatic test_directed_extremes();
        sender_idle_max   = 3;
        receiver_idle_max = 3;
        send_pixel({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_pixel({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        send_pixel({32'hffff_ffff, 32'h0000_0000, 32'h0000_0000});
        send_pixel({32'h0000_0000, 32'hffff_ffff, 32'h0000_0000});
        send_pixel({32'h0000_0000, 32'h0000_0000, 32'hffff_ffff});
        send_pixel({32'h0000_0001, 32'h0000_0002, 32'h0000_0003});
        send_pixel({32'h0000_0010, 32'h0000_0011, 32'h0000_0012});
        send_pixel({32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
        send_pixel({32'h0000_ffff, 32'h0001_0001, 32'h7fff_ffff});
        send_pixel({32'h8000_0000, 32'h0fff_0000, 32'h0ffe_ffff});
        send_pixel({32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0});
        send_pixel({32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f});
        send_pixel({32'h0000_0100, 32'h0010_0000, 32'h0100_0000});
        send_pixel({32'h0000_8000, 32'h0000_4000, 32'h0002_0000});
        send_pixel({32'hfffe_0000, 32'h0000_0080, 32'h0003_0000});
        wait_for_results();
    endtask

    // the receiver holds off while items keep coming, so the pipe fills
    task automatic test_backpressure_fill();
        sender_idle_max   = 0;
        receiver_idle_max = 0;
        hold_request      = 90;
        run_random(70, 0, 0);
    endtask

    task automatic test_random_streaming();
        run_random(320, 0, 0);
    endtask

    task automatic test_random_input_idle();
        run_random(250, 17, 0);
    endtask

    task automatic test_random_output_stall();
        run_random(250, 0, 17);
    endtask

    task automatic test_random_both_idle();
        run_random(450, 17, 17);
    endtask

    task automatic test_drain_pause();
        rtmg_pkg::pixel_t p;
        sender_idle_max   = 5;
        receiver_idle_max = 5;
        for (int i = 0; i < 10; i++)
        begin
            p.red_radiance   = random_radiance();
            p.green_radiance = random_radiance();
            p.blue_radiance  = random_radiance();
            send_pixel(p);
            if (i % 3 == 2)
            begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    // receiver side
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                n            = hold_request;
                hold_request = 0;
            end
            else
            begin
                n = idle_draw(receiver_idle_max);
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
                result_stall <= 1'b0;
            end
            do
            begin
                @(posedge clk);
            end
            while (!result_valid);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        rtmg_pkg::result_t want;
        if (rst_n)
        begin
            if (pixel_valid && pixel_stall)
            begin
                input_stall_cycles++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("unexpected result r=%0d g=%0d b=%0d",
                                 result_out.red_byte, result_out.green_byte,
                                 result_out.blue_byte);
                    end
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    results_checked++;
                    if (want.red_byte == 8'd254 || want.green_byte == 8'd254
                        || want.blue_byte == 8'd254)
                    begin
                        saturated_bytes++;
                    end
                    if (want.red_byte == 8'd0 || want.green_byte == 8'd0
                        || want.blue_byte == 8'd0)
                    begin
                        zero_bytes++;
                    end
                    if (result_out.red_byte !== want.red_byte
                        || result_out.green_byte !== want.green_byte
                        || result_out.blue_byte !== want.blue_byte)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display({"mismatch: expected r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     want.red_byte, want.green_byte, want.blue_byte,
                                     result_out.red_byte, result_out.green_byte,
                                     result_out.blue_byte);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        failures           = 0;
        pixels_sent        = 0;
        results_checked    = 0;
        saturated_bytes    = 0;
        zero_bytes         = 0;
        input_stall_cycles = 0;
        sender_idle_max    = 0;
        receiver_idle_max  = 0;
        hold_request       = 0;
        pixel_valid        = 1'b0;
        pixel_in           = '0;
        rst_n              = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_drain_pause();
        test_backpressure_fill();
        test_random_streaming();
        test_random_input_idle();
        test_random_output_stall();
        test_random_both_idle();

        wait_for_results();
        repeat (rtmg_pkg::LATENCY + 8) @(posedge clk);

        $display("sent %0d pixels and checked %0d results under idling and backpressure",
                 pixels_sent, results_checked);
        $display("%0d results held a saturated byte, %0d a zero byte, input stalled %0d cycles",
                 saturated_bytes, zero_bytes, input_stall_cycles);
        if (failures == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches in total", failures);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
design/rtmg_pkg.sv
design/rtmg_div.sv
design/rtmg_gamma.sv
design/reinhard_tone_map_gamma_top.sv
design/rtmg_checker.sv
test/reinhard_tone_map_gamma_top_test.sv
